FILE: sv/labmr_pkg.sv
// Shared constants, codes and types for the angular min-range binning block.
package labmr_pkg;

    localparam int NUM_BINS = 629;
    localparam int BIN_W = 10;
    localparam int ANGLE_W = 19;
    localparam int DIST_W = 16;
    localparam int STR_W = 8;
    localparam int SHIFT_W = 20;
    localparam int SCALE_W = 23;
    localparam int PROD_W = SHIFT_W + SCALE_W;
    localparam int FRAC_W = 32;

    localparam logic [ANGLE_W-1:0] HALF_TURN_MDEG = ANGLE_W'(180000);
    // round(pi / 1800 * 2^32), unsigned Q0.32
    localparam logic [SCALE_W-1:0] BIN_SCALE = SCALE_W'(7496132);
    localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(NUM_BINS - 1);

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic CMD_ACC = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef struct packed {
        logic              cmd;
        logic [BIN_W-1:0]  bin;
        logic [DIST_W-1:0] distance;
        logic [STR_W-1:0]  str;
    } item_t;

    typedef struct packed {
        logic              valid;
        logic [DIST_W-1:0] range_cm;
        logic [STR_W-1:0]  str;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

FILE: sv/labmr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module labmr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/labmr_front.sv
// Front end: takes items, folds the angle and maps it to a bin.
module labmr_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             cmd,
    input  logic [labmr_pkg::ANGLE_W-1:0]    angle_mdeg,
    input  logic [labmr_pkg::DIST_W-1:0]     distance_cm,
    input  logic [labmr_pkg::STR_W-1:0]      strength,
    input  logic [labmr_pkg::BIN_W-1:0]      read_bin,
    input  logic                             clearing,
    input  logic [labmr_pkg::QCNT_W-1:0]     q_count,
    output logic                             push,
    output labmr_pkg::item_t                 push_item
);

    logic                              accept;
    logic                              v_reg;
    logic                              cmd_reg;
    logic [labmr_pkg::SHIFT_W-1:0]     s_reg;
    logic [labmr_pkg::SHIFT_W-1:0]     s_next;
    logic [labmr_pkg::DIST_W-1:0]      dist_reg;
    logic [labmr_pkg::STR_W-1:0]       str_reg;
    logic [labmr_pkg::BIN_W-1:0]       rbin_reg;
    logic [labmr_pkg::QCNT_W:0]        occ;
    logic [labmr_pkg::PROD_W-1:0]      prod;
    logic [labmr_pkg::PROD_W-labmr_pkg::FRAC_W-1:0] bin_raw;
    logic [labmr_pkg::BIN_W-1:0]       bin_sat;

    // queue slots already spoken for, including the item in this stage
    assign occ = {1'b0, q_count} + {{labmr_pkg::QCNT_W{1'b0}}, v_reg};
    assign busy = clearing || (occ >= (labmr_pkg::QCNT_W+1)'(labmr_pkg::QDEPTH));
    assign accept = start && !busy;

    always_comb
    begin
        if (angle_mdeg <= labmr_pkg::HALF_TURN_MDEG)
        begin
            s_next = labmr_pkg::SHIFT_W'(angle_mdeg)
                   + labmr_pkg::SHIFT_W'(labmr_pkg::HALF_TURN_MDEG);
        end
        else
        begin
            s_next = labmr_pkg::SHIFT_W'(angle_mdeg)
                   - labmr_pkg::SHIFT_W'(labmr_pkg::HALF_TURN_MDEG);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else
        begin
            v_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= cmd;
            s_reg    <= s_next;
            dist_reg <= distance_cm;
            str_reg  <= strength;
            rbin_reg <= read_bin;
        end
    end

    assign prod = labmr_pkg::PROD_W'(s_reg) * labmr_pkg::PROD_W'(labmr_pkg::BIN_SCALE);
    assign bin_raw = prod[labmr_pkg::PROD_W-1:labmr_pkg::FRAC_W];

    always_comb
    begin
        if (bin_raw > ($bits(bin_raw))'(labmr_pkg::LAST_BIN))
        begin
            bin_sat = labmr_pkg::LAST_BIN;
        end
        else
        begin
            bin_sat = labmr_pkg::BIN_W'(bin_raw);
        end
    end

    assign push = v_reg;

    always_comb
    begin
        push_item.cmd      = cmd_reg;
        push_item.bin      = (cmd_reg == labmr_pkg::CMD_READ) ? rbin_reg : bin_sat;
        push_item.distance = dist_reg;
        push_item.str      = str_reg;
    end

endmodule

FILE: sv/labmr_queue.sv
// Short item queue between the front end and the bin store.
module labmr_queue (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  labmr_pkg::item_t             push_item,
    input  logic                         pop,
    output labmr_pkg::item_t             head,
    output logic                         empty,
    output logic [labmr_pkg::QCNT_W-1:0] count
);

    labmr_pkg::item_t                slots [labmr_pkg::QDEPTH];
    logic [labmr_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [labmr_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [labmr_pkg::QCNT_W-1:0]    count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + labmr_pkg::QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + labmr_pkg::QPTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + labmr_pkg::QCNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - labmr_pkg::QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_item;
        end
    end

    assign head  = slots[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign count = count_reg;

endmodule

FILE: sv/labmr_back.sv
// Back end: clears the bin store, then runs read-modify-write per item.
module labmr_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  labmr_pkg::item_t              head,
    input  logic                          q_empty,
    output logic                          pop,
    output logic                          clearing,
    output logic                          done,
    output logic [labmr_pkg::BIN_W-1:0]   out_bin,
    output logic                          bin_empty,
    output logic [labmr_pkg::DIST_W-1:0]  out_range_cm,
    output logic [labmr_pkg::STR_W-1:0]   out_strength
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t                             state_reg;
    logic [labmr_pkg::BIN_W-1:0]        clr_cnt_reg;
    labmr_pkg::item_t                   cur_reg;
    logic                               done_reg;
    logic [labmr_pkg::BIN_W-1:0]        out_bin_reg;
    logic                               bin_empty_reg;
    logic [labmr_pkg::DIST_W-1:0]       out_range_reg;
    logic [labmr_pkg::STR_W-1:0]        out_str_reg;

    logic                               we;
    logic [labmr_pkg::BIN_W-1:0]        waddr;
    labmr_pkg::entry_t                  wentry;
    logic                               re;
    labmr_pkg::entry_t                  rentry;
    logic [labmr_pkg::ENTRY_W-1:0]      rdata;
    logic                               cur_in_range;
    logic                               hit;
    logic                               take;

    assign rentry = labmr_pkg::entry_t'(rdata);
    assign cur_in_range = (cur_reg.bin <= labmr_pkg::LAST_BIN);
    assign hit  = cur_in_range && rentry.valid;
    assign take = !rentry.valid || (cur_reg.distance < rentry.range_cm);

    assign clearing = (state_reg == ST_CLEAR);
    assign pop = (state_reg == ST_IDLE) && !q_empty;
    // out-of-range read bins never touch the store
    assign re  = pop && (head.bin <= labmr_pkg::LAST_BIN);

    always_comb
    begin
        we = 1'b0;
        waddr = cur_reg.bin;
        wentry = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                we = 1'b1;
                waddr = clr_cnt_reg;
            end
            ST_EXEC:
            begin
                if (cur_reg.cmd == labmr_pkg::CMD_ACC)
                begin
                    we = take;
                    wentry.valid = 1'b1;
                    wentry.range_cm = cur_reg.distance;
                    wentry.str = cur_reg.str;
                end
                else
                begin
                    we = hit;
                end
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            done_reg      <= 1'b0;
            out_bin_reg   <= '0;
            bin_empty_reg <= 1'b0;
            out_range_reg <= '0;
            out_str_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                ST_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + labmr_pkg::BIN_W'(1);
                    if (clr_cnt_reg == labmr_pkg::LAST_BIN)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (pop)
                    begin
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC:
                begin
                    state_reg <= ST_IDLE;
                    if (cur_reg.cmd == labmr_pkg::CMD_READ)
                    begin
                        done_reg      <= 1'b1;
                        out_bin_reg   <= cur_reg.bin;
                        bin_empty_reg <= !hit;
                        out_range_reg <= hit ? rentry.range_cm : '0;
                        out_str_reg   <= hit ? rentry.str : '0;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= head;
        end
    end

    labmr_ram #(
        .WIDTH (labmr_pkg::ENTRY_W),
        .DEPTH (labmr_pkg::NUM_BINS)
    ) u_bin_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wentry),
        .re    (re),
        .raddr (head.bin),
        .rdata (rdata)
    );

    assign done         = done_reg;
    assign out_bin      = out_bin_reg;
    assign bin_empty    = bin_empty_reg;
    assign out_range_cm = out_range_reg;
    assign out_strength = out_str_reg;

endmodule

FILE: sv/lidar_angular_bin_min_range.sv
// Top level: angular binning of lidar samples keeping the nearest return per bin.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------------
//  item in  | start, busy          | cmd, angle_mdeg, distance_cm, strength, read_bin
//  result   | done (1-cycle strobe)| out_bin, bin_empty, out_range_cm, out_strength
//
// After reset busy stays high while all 629 bins of the RAM are swept empty.
// The front end folds the angle as the item is taken and multiplies in the next
// cycle, then feeds a 4-deep queue; busy rises when the queue and the mapping
// stage hold four items.
// The back end takes each item through a RAM read (ST_IDLE, as it pops), then a compare
// and write (ST_EXEC), and pops no new item until that write is done.
// A read result passes the front-end stage registers, a queue slot, the RAM read and the result registers.
// Results cannot be held off; done is high for exactly one cycle.
module lidar_angular_bin_min_range (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          cmd,
    input  logic [labmr_pkg::ANGLE_W-1:0] angle_mdeg,
    input  logic [labmr_pkg::DIST_W-1:0]  distance_cm,
    input  logic [labmr_pkg::STR_W-1:0]   strength,
    input  logic [labmr_pkg::BIN_W-1:0]   read_bin,
    output logic                          done,
    output logic [labmr_pkg::BIN_W-1:0]   out_bin,
    output logic                          bin_empty,
    output logic [labmr_pkg::DIST_W-1:0]  out_range_cm,
    output logic [labmr_pkg::STR_W-1:0]   out_strength
);

    logic                          clearing;
    logic                          push;
    labmr_pkg::item_t              push_item;
    logic                          pop;
    labmr_pkg::item_t              head;
    logic                          q_empty;
    logic [labmr_pkg::QCNT_W-1:0]  q_count;

    labmr_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .angle_mdeg  (angle_mdeg),
        .distance_cm (distance_cm),
        .strength    (strength),
        .read_bin    (read_bin),
        .clearing    (clearing),
        .q_count     (q_count),
        .push        (push),
        .push_item   (push_item)
    );

    labmr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .empty     (q_empty),
        .count     (q_count)
    );

    labmr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .q_empty      (q_empty),
        .pop          (pop),
        .clearing     (clearing),
        .done         (done),
        .out_bin      (out_bin),
        .bin_empty    (bin_empty),
        .out_range_cm (out_range_cm),
        .out_strength (out_strength)
    );

endmodule

FILE: verif/tb_lidar_angular_bin_min_range.sv
// Testbench for the angular min-range binning block: directed rows, then random items.
`timescale 1ns / 1ps

module tb_lidar_angular_bin_min_range;

    localparam int RANDOM_ITEMS = 1300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 24;
    localparam int MAX_SHOWN = 10;
    localparam int ANGLE_TOP = 359999;
    localparam int HOT_COUNT = 8;

    typedef struct packed {
        logic [labmr_pkg::BIN_W-1:0]  bin_idx;
        logic                         empty;
        logic [labmr_pkg::DIST_W-1:0] range_cm;
        logic [labmr_pkg::STR_W-1:0]  strength;
    } bin_report_t;

    typedef struct packed {
        logic                          cmd;
        logic [labmr_pkg::ANGLE_W-1:0] angle;
        logic [labmr_pkg::DIST_W-1:0]  distance;
        logic [labmr_pkg::STR_W-1:0]   strength;
        logic [labmr_pkg::BIN_W-1:0]   rbin;
        logic                          typed;
        bin_report_t                   want;
    } stim_row_t;

    logic                          clk;
    logic                          rst_n;
    logic                          start;
    logic                          busy;
    logic                          cmd;
    logic [labmr_pkg::ANGLE_W-1:0] angle_mdeg;
    logic [labmr_pkg::DIST_W-1:0]  distance_cm;
    logic [labmr_pkg::STR_W-1:0]   strength;
    logic [labmr_pkg::BIN_W-1:0]   read_bin;
    logic                          done;
    logic [labmr_pkg::BIN_W-1:0]   out_bin;
    logic                          bin_empty;
    logic [labmr_pkg::DIST_W-1:0]  out_range_cm;
    logic [labmr_pkg::STR_W-1:0]   out_strength;

    // travels with the item so the monitor knows whether a typed answer applies
    logic                          cur_typed;
    bin_report_t                   cur_want;

    // shadow of the bin store
    logic                          near_valid [labmr_pkg::NUM_BINS];
    logic [labmr_pkg::DIST_W-1:0]  near_range [labmr_pkg::NUM_BINS];
    logic [labmr_pkg::STR_W-1:0]   near_strength [labmr_pkg::NUM_BINS];

    bin_report_t                   pending_reports [$];
    stim_row_t                     directed_rows [$];
    logic [labmr_pkg::ANGLE_W-1:0] hot_angles [HOT_COUNT];

    int fail_count = 0;
    int idle_cycles = 0;
    int n_samples = 0;
    int n_reads = 0;
    int n_filled = 0;
    int n_out_of_range = 0;

    lidar_angular_bin_min_range i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .angle_mdeg   (angle_mdeg),
        .distance_cm  (distance_cm),
        .strength     (strength),
        .read_bin     (read_bin),
        .done         (done),
        .out_bin      (out_bin),
        .bin_empty    (bin_empty),
        .out_range_cm (out_range_cm),
        .out_strength (out_strength)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [labmr_pkg::BIN_W-1:0] map_angle_to_bin(
        input logic [labmr_pkg::ANGLE_W-1:0] angle);
        logic [labmr_pkg::SHIFT_W-1:0] shifted;
        logic [63:0]                   product;
        if (angle <= labmr_pkg::HALF_TURN_MDEG)
            shifted = labmr_pkg::SHIFT_W'(angle)
                    + labmr_pkg::SHIFT_W'(labmr_pkg::HALF_TURN_MDEG);
        else
            shifted = labmr_pkg::SHIFT_W'(angle)
                    - labmr_pkg::SHIFT_W'(labmr_pkg::HALF_TURN_MDEG);
        product = (64'(shifted) * 64'(labmr_pkg::BIN_SCALE)) >> labmr_pkg::FRAC_W;
        if (product > 64'(labmr_pkg::LAST_BIN))
            product = 64'(labmr_pkg::LAST_BIN);
        return product[labmr_pkg::BIN_W-1:0];
    endfunction

    // Applies one item to the shadow store; a read yields a report.
    task automatic fold_item_into_bins(input stim_row_t it, output bit makes_report,
                                       output bin_report_t rep);
        logic [labmr_pkg::BIN_W-1:0] b;
        makes_report = 1'b0;
        rep = '0;
        if (it.cmd == labmr_pkg::CMD_ACC)
        begin
            b = map_angle_to_bin(it.angle);
            if (!near_valid[b] || it.distance < near_range[b])
            begin
                near_valid[b] = 1'b1;
                near_range[b] = it.distance;
                near_strength[b] = it.strength;
            end
        end
        else
        begin
            makes_report = 1'b1;
            rep.bin_idx = it.rbin;
            rep.empty = 1'b1;
            if (it.rbin < labmr_pkg::BIN_W'(labmr_pkg::NUM_BINS) && near_valid[it.rbin])
            begin
                rep.empty = 1'b0;
                rep.range_cm = near_range[it.rbin];
                rep.strength = near_strength[it.rbin];
                near_valid[it.rbin] = 1'b0;
            end
        end
    endtask

    function automatic stim_row_t acc_row(input int angle, input int dist_val, input int str);
        stim_row_t r;
        r = '0;
        r.cmd = labmr_pkg::CMD_ACC;
        r.angle = labmr_pkg::ANGLE_W'(angle);
        r.distance = labmr_pkg::DIST_W'(dist_val);
        r.strength = labmr_pkg::STR_W'(str);
        r.rbin = labmr_pkg::BIN_W'($urandom);
        return r;
    endfunction

    function automatic stim_row_t rd_row(input int b, input bit typed);
        stim_row_t r;
        r = '0;
        r.cmd = labmr_pkg::CMD_READ;
        r.angle = labmr_pkg::ANGLE_W'($urandom);
        r.distance = labmr_pkg::DIST_W'($urandom);
        r.strength = labmr_pkg::STR_W'($urandom);
        r.rbin = labmr_pkg::BIN_W'(b);
        r.typed = typed;
        // only empty bins get a typed answer
        r.want.bin_idx = labmr_pkg::BIN_W'(b);
        r.want.empty = 1'b1;
        return r;
    endfunction

    function automatic stim_row_t random_row();
        stim_row_t r;
        int pick;
        int a;
        pick = $urandom_range(0, 99);
        if (pick < 68)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
            begin
                a = int'(hot_angles[$urandom_range(0, HOT_COUNT-1)]) + $urandom_range(0, 400);
                if (a > ANGLE_TOP)
                    a = a - ANGLE_TOP - 1;
            end
            else if (pick < 85)
                a = $urandom_range(0, ANGLE_TOP);
            else if (pick < 95)
            begin
                case ($urandom_range(0, 5))
                    0: a = 0;
                    1: a = 1;
                    2: a = 179999;
                    3: a = 180000;
                    4: a = 180001;
                    default: a = ANGLE_TOP;
                endcase
            end
            else
                a = $urandom_range(ANGLE_TOP + 1, (1 << labmr_pkg::ANGLE_W) - 1);
            r = acc_row(a, 0, $urandom_range(0, 255));
            pick = $urandom_range(0, 99);
            if (pick < 40)
                r.distance = labmr_pkg::DIST_W'($urandom_range(0, 15));   // dense values give ties
            else if (pick < 50)
                r.distance = pick[0] ? '1 : '0;
            else
                r.distance = labmr_pkg::DIST_W'($urandom);
        end
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
                r = rd_row(map_angle_to_bin(hot_angles[$urandom_range(0, HOT_COUNT-1)]), 1'b0);
            else if (pick < 90)
                r = rd_row($urandom_range(0, labmr_pkg::NUM_BINS - 1), 1'b0);
            else
                r = rd_row($urandom_range(labmr_pkg::NUM_BINS, (1 << labmr_pkg::BIN_W) - 1),
                           1'b0);
        end
        return r;
    endfunction

    function automatic int pick_gap(input bit no_idle);
        int pick;
        if (no_idle)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic offer_item(input stim_row_t r);
        start <= 1'b1;
        cmd <= r.cmd;
        angle_mdeg <= r.angle;
        distance_cm <= r.distance;
        strength <= r.strength;
        read_bin <= r.rbin;
        cur_typed <= r.typed;
        cur_want <= r.want;
        do
            @(posedge clk);
        while (busy);
    endtask

    // start is lowered only when at least one cycle of idling follows
    task automatic idle_gap(input int n);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic note_failure(input string what, input bin_report_t want,
                                input bin_report_t got);
        fail_count++;
        if (fail_count <= MAX_SHOWN)
        begin
            $write("mismatch (%s) at %0t: want bin %0d empty %0d range %0d str %0d, ",
                   what, $realtime, want.bin_idx, want.empty, want.range_cm, want.strength);
            $display("got bin %0d empty %0d range %0d str %0d",
                     got.bin_idx, got.empty, got.range_cm, got.strength);
        end
    endtask

    // result checking on done and prediction at each accepting edge
    always @(posedge clk)
    begin
        bin_report_t got;
        bin_report_t want;
        bin_report_t predicted;
        stim_row_t   it;
        bit          makes_report;
        if (rst_n)
        begin
            if (done)
            begin
                got = '{out_bin, bin_empty, out_range_cm, out_strength};
                if (pending_reports.size() == 0)
                    note_failure("unexpected result", '0, got);
                else
                begin
                    want = pending_reports.pop_front();
                    if (got.bin_idx !== want.bin_idx || got.empty !== want.empty
                        || got.range_cm !== want.range_cm || got.strength !== want.strength)
                        note_failure("field", want, got);
                    if (!want.empty)
                        n_filled++;
                end
            end
            if (start && !busy)
            begin
                it = '{cmd, angle_mdeg, distance_cm, strength, read_bin, cur_typed, cur_want};
                fold_item_into_bins(it, makes_report, predicted);
                if (makes_report)
                begin
                    pending_reports.push_back(cur_typed ? cur_want : predicted);
                    n_reads++;
                    if (read_bin >= labmr_pkg::BIN_W'(labmr_pkg::NUM_BINS))
                        n_out_of_range++;
                end
                else
                    n_samples++;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: no item or result for %0d cycles, %0d results outstanding",
                     idle_cycles, pending_reports.size());
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        start <= 1'b0;
        cmd <= labmr_pkg::CMD_ACC;
        angle_mdeg <= '0;
        distance_cm <= '0;
        strength <= '0;
        read_bin <= '0;
        cur_typed <= 1'b0;
        cur_want <= '0;
        for (int k = 0; k < labmr_pkg::NUM_BINS; k++)
        begin
            near_valid[k] = 1'b0;
            near_range[k] = '0;
            near_strength[k] = '0;
        end
        for (int k = 0; k < HOT_COUNT; k++)
            hot_angles[k] = labmr_pkg::ANGLE_W'($urandom_range(0, ANGLE_TOP));

        // every bin is empty after reset; out-of-range reads report empty
        directed_rows.push_back(rd_row(0, 1'b1));
        directed_rows.push_back(rd_row(labmr_pkg::NUM_BINS - 1, 1'b1));
        directed_rows.push_back(rd_row((1 << labmr_pkg::BIN_W) - 1, 1'b1));
        directed_rows.push_back(rd_row(labmr_pkg::NUM_BINS, 1'b1));
        // an empty bin takes even the largest distance
        directed_rows.push_back(acc_row(0, 65535, 255));
        directed_rows.push_back(rd_row(314, 1'b0));
        // equal distance keeps the stored sample, smaller replaces it
        directed_rows.push_back(acc_row(180000, 100, 1));
        directed_rows.push_back(acc_row(180000, 100, 2));
        directed_rows.push_back(acc_row(179999, 99, 3));
        directed_rows.push_back(acc_row(180000, 0, 4));
        directed_rows.push_back(rd_row(labmr_pkg::NUM_BINS - 1, 1'b0));
        // fold edges and an angle past a full turn
        directed_rows.push_back(acc_row(180001, 0, 0));
        directed_rows.push_back(acc_row(1, 65535, 255));
        directed_rows.push_back(acc_row(ANGLE_TOP, 5, 7));
        directed_rows.push_back(acc_row((1 << labmr_pkg::ANGLE_W) - 1, 1234, 170));
        directed_rows.push_back(rd_row(0, 1'b0));
        directed_rows.push_back(rd_row(314, 1'b0));
        directed_rows.push_back(rd_row(map_angle_to_bin('1), 1'b0));
        directed_rows.push_back(rd_row(314, 1'b0));
        directed_rows.push_back(rd_row(labmr_pkg::NUM_BINS - 1, 1'b0));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[k])
        begin
            idle_gap(pick_gap(1'b0));
            offer_item(directed_rows[k]);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if ($urandom_range(0, 63) == 0)
                hot_angles[$urandom_range(0, HOT_COUNT-1)] =
                    labmr_pkg::ANGLE_W'($urandom_range(0, ANGLE_TOP));
            if (n == RANDOM_ITEMS / 2)
            begin
                // hold off until every outstanding result is back
                start <= 1'b0;
                do
                    @(posedge clk);
                while (pending_reports.size() != 0);
            end
            else
                idle_gap(pick_gap((n % 256) < 48));
            offer_item(random_row());
        end

        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_reports.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (pending_reports.size() != 0)
            fail_count++;
        $display("covered %0d samples and %0d bin reads (%0d out of range), %0d reads found a range",
                 n_samples, n_reads, n_out_of_range, n_filled);
        $display("%0d mismatches", fail_count);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

FILE: filelist.f
sv/labmr_pkg.sv
sv/labmr_ram.sv
sv/labmr_front.sv
sv/labmr_queue.sv
sv/labmr_back.sv
sv/lidar_angular_bin_min_range.sv
verif/tb_lidar_angular_bin_min_range.sv
